/* rtl/core/dgt_pkg.sv */
package dgt_pkg;

   localparam int MAX_POWER  = 4;
   localparam int COORD_BITS = 32;
   localparam int CW         = 32;
   localparam int PW         = 3;
   localparam int CNT_W      = $clog2((1 << MAX_POWER) + 2);
   localparam int IDX_W      = 9;
   localparam int TOL_W      = 20;
   localparam int CSR_AW     = 3;
   localparam int LW         = CW + MAX_POWER + 2;
   localparam int NW         = CW + 2 * MAX_POWER + 3;
   localparam int DW         = 2 * CW - 16;
   localparam int SW         = ((NW > DW) ? NW : DW) + 1;
   localparam int REQ_DW     = 136;
   localparam int RSP_DW     = 128;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_BEGIN  = 2'd1;
   localparam logic [1:0] FUNC_VERTEX = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_VERTEX = 2'd1;
   localparam logic [1:0] KIND_TRI    = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_GRID_POWER = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_START_X    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_START_Y    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_START_Z    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_TOLERANCE  = 3'd4;

   localparam logic [2:0] CALC_LAST_STEP = 3'd4;
   localparam logic [2:0] CALC_WR_STEP   = 3'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RES_STATUS,
      RES_VERTEX,
      RES_TRI0,
      RES_TRI1
   } res_sel_type;

   typedef struct packed {
      logic        load_corner;
      logic        align_done;
      logic        align_ok;
      logic        rotate;
      logic        latch;
      logic        calc;
      logic [2:0]  step;
      logic        out_load;
      res_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic vertex_ok;
      logic match;
      logic tris;
      logic out_free;
   } stat_type;

endpackage

/* rtl/core/dgt_ctrl.sv */
module dgt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        func,
   input  dgt_pkg::stat_type stat,
   output dgt_pkg::cmd_type  cmd
);
   import dgt_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] k_ff, k_in;
   logic       mode_status_ff, mode_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         k_ff           <= '0;
         mode_status_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         k_ff           <= k_in;
         mode_status_ff <= mode_status_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      k_in           = k_ff;
      mode_status_in = mode_status_ff;
      cmd            = '0;
      cmd.out_sel    = RES_STATUS;
      cmd.step       = step_ff;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               priority if (func == FUNC_LOAD) begin
                  cmd.load_corner = 1'b1;
               end else if (func == FUNC_BEGIN) begin
                  step_in  = '0;
                  state_in = ST_ALIGN;
               end else if (func == FUNC_VERTEX && stat.vertex_ok) begin
                  cmd.latch = 1'b1;
                  step_in   = '0;
                  state_in  = ST_CALC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ALIGN: begin
            // try the current order, then rotate; the fourth rotation restores the quad
            if (stat.match) begin
               cmd.align_done = 1'b1;
               cmd.align_ok   = 1'b1;
            end else begin
               cmd.rotate = 1'b1;
               if (step_ff == 3'd3) begin
                  cmd.align_done = 1'b1;
               end
            end
            step_in = step_ff + 3'd1;
            if (cmd.align_done) begin
               mode_status_in = 1'b1;
               k_in           = '0;
               state_in       = ST_EMIT;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            step_in  = step_ff + 3'd1;
            if (step_ff == CALC_LAST_STEP) begin
               mode_status_in = 1'b0;
               k_in           = '0;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (mode_status_ff) begin
                  cmd.out_sel  = RES_STATUS;
                  cmd.out_last = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  unique case (k_ff)
                     2'd0: begin
                        cmd.out_sel  = RES_VERTEX;
                        cmd.out_last = !stat.tris;
                        if (!stat.tris) state_in = ST_IDLE;
                     end
                     2'd1: begin
                        cmd.out_sel = RES_TRI0;
                     end
                     default: begin
                        cmd.out_sel  = RES_TRI1;
                        cmd.out_last = 1'b1;
                        state_in     = ST_IDLE;
                     end
                  endcase
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/core/dgt_datapath.sv */
module dgt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dgt_pkg::CSR_AW-1:0]          csr_addr,
   input  logic [dgt_pkg::CW-1:0]              csr_wdata,
   input  logic [1:0]                          corner,
   input  logic signed [dgt_pkg::CW-1:0]       ax,
   input  logic signed [dgt_pkg::CW-1:0]       ay,
   input  logic signed [dgt_pkg::CW-1:0]       az,
   input  logic signed [dgt_pkg::CW-1:0]       dist_req,
   input  dgt_pkg::cmd_type                    cmd,
   output dgt_pkg::stat_type                   stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [1:0]                          kind,
   output logic                                status,
   output logic signed [dgt_pkg::CW-1:0]       ox,
   output logic signed [dgt_pkg::CW-1:0]       oy,
   output logic signed [dgt_pkg::CW-1:0]       oz,
   output logic [dgt_pkg::IDX_W-1:0]           tri_a,
   output logic [dgt_pkg::IDX_W-1:0]           tri_b,
   output logic [dgt_pkg::IDX_W-1:0]           tri_c,
   output logic                                last
);
   import dgt_pkg::*;

   localparam logic signed [2*CW-1:0] D_HALF = (2*CW)'(1) <<< 15;
   localparam logic signed [SW-1:0]   SAT_HI = (SW'(1) <<< (COORD_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0]   SAT_LO = -SAT_HI - SW'(1);

   // registers
   logic [PW-1:0]          power_ff;
   logic signed [CW-1:0]   sx_ff, sy_ff, sz_ff;
   logic [TOL_W-1:0]       tol_ff;
   logic signed [CW-1:0]   cx_ff [4];
   logic signed [CW-1:0]   cy_ff [4];
   logic signed [CW-1:0]   cz_ff [4];
   logic                   align_ok_ff, fail_ff;
   logic [CNT_W-1:0]       row_ff, col_ff;
   logic [CNT_W-1:0]       r_ff, c_ff;
   logic signed [CW-1:0]   dx_ff, dy_ff, dz_ff, dist_ff;
   logic signed [LW-1:0]   l_ff, rr_ff;
   logic signed [2*CW-1:0] prod_ff;
   logic [1:0]             axa_ff, axb_ff;
   logic signed [NW-1:0]   num_ff;
   logic signed [DW-1:0]   d_ff;
   logic signed [CW-1:0]   vx_ff [3];

   logic                   out_valid_ff;
   logic [1:0]             kind_ff;
   logic                   status_ff, last_ff;
   logic signed [CW-1:0]   ox_ff, oy_ff, oz_ff;
   logic [IDX_W-1:0]       ta_ff, tb_ff, tc_ff;

   // effective power and grid size
   logic [PW-1:0]    p;
   logic [CNT_W-1:0] n, w;

   always_comb begin
      priority if (power_ff == '0) p = PW'(1);
      else if (power_ff > PW'(MAX_POWER)) p = PW'(MAX_POWER);
      else p = power_ff;
      n = CNT_W'(1) << p;
      w = n + CNT_W'(1);
   end

   // corner match against start position
   logic signed [CW:0] ddx, ddy, ddz, adx, ady, adz, tol_s;
   always_comb begin
      ddx   = (CW+1)'(cx_ff[0]) - (CW+1)'(sx_ff);
      ddy   = (CW+1)'(cy_ff[0]) - (CW+1)'(sy_ff);
      ddz   = (CW+1)'(cz_ff[0]) - (CW+1)'(sz_ff);
      adx   = (ddx < 0) ? -ddx : ddx;
      ady   = (ddy < 0) ? -ddy : ddy;
      adz   = (ddz < 0) ? -ddz : ddz;
      tol_s = signed'((CW+1)'(tol_ff));
   end

   assign stat.match     = (adx <= tol_s) && (ady <= tol_s) && (adz <= tol_s);
   assign stat.vertex_ok = align_ok_ff && (row_ff <= n) && (col_ff <= n);
   assign stat.tris      = (r_ff != '0) && (c_ff != '0);
   assign stat.out_free  = !out_valid_ff || rsp_tready;

   // stage A: edge points of the row and displacement product
   logic signed [CW-1:0]        a0, a1, a2, a3, adir;
   logic signed [CW:0]          d10, d23;
   logic signed [CNT_W:0]       rs, cs;
   logic signed [CW+CNT_W+1:0]  m10, m23;
   logic signed [LW-1:0]        l_in, rr_in;
   logic signed [2*CW-1:0]      prod_in;

   always_comb begin
      unique case (cmd.step[1:0])
         2'd0: begin
            a0 = cx_ff[0]; a1 = cx_ff[1]; a2 = cx_ff[2]; a3 = cx_ff[3]; adir = dx_ff;
         end
         2'd1: begin
            a0 = cy_ff[0]; a1 = cy_ff[1]; a2 = cy_ff[2]; a3 = cy_ff[3]; adir = dy_ff;
         end
         default: begin
            a0 = cz_ff[0]; a1 = cz_ff[1]; a2 = cz_ff[2]; a3 = cz_ff[3]; adir = dz_ff;
         end
      endcase
      rs      = signed'({1'b0, r_ff});
      cs      = signed'({1'b0, c_ff});
      d10     = (CW+1)'(a1) - (CW+1)'(a0);
      d23     = (CW+1)'(a2) - (CW+1)'(a3);
      m10     = d10 * rs;
      m23     = d23 * rs;
      l_in    = (LW'(a0) <<< p) + LW'(m10);
      rr_in   = (LW'(a3) <<< p) + LW'(m23);
      prod_in = adir * dist_ff;
   end

   // stage B: blend along the column, round the displacement
   logic signed [NW-1:0]       diff;
   logic signed [NW+CNT_W:0]   mcol;
   logic signed [NW-1:0]       num_in;
   logic signed [2*CW-1:0]     prod_r;

   always_comb begin
      diff   = NW'(rr_ff) - NW'(l_ff);
      mcol   = diff * cs;
      num_in = (NW'(l_ff) <<< p) + NW'(mcol);
      prod_r = (prod_ff + D_HALF) >>> 16;
   end

   // stage C: divide by n*n with rounding, add, saturate
   logic signed [NW-1:0] rnd, bsh;
   logic signed [SW-1:0] sum;
   logic signed [CW-1:0] sat;
   logic [PW:0]          sh2;

   always_comb begin
      sh2 = {p, 1'b0};
      rnd = NW'(1) <<< (sh2 - (PW+1)'(1));
      bsh = (num_ff + rnd) >>> sh2;
      sum = SW'(bsh) + SW'(d_ff);
      priority if (sum > SAT_HI) sat = CW'(SAT_HI);
      else if (sum < SAT_LO) sat = CW'(SAT_LO);
      else sat = CW'(sum);
   end

   // triangle indices of the cell above and to the left
   logic [IDX_W-1:0] idx, i1, iw, iw1;
   always_comb begin
      idx = IDX_W'(r_ff - CNT_W'(1)) * IDX_W'(w) + IDX_W'(c_ff - CNT_W'(1));
      i1  = idx + IDX_W'(1);
      iw  = idx + IDX_W'(w);
      iw1 = iw + IDX_W'(1);
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff     <= PW'(2);
         sx_ff        <= '0;
         sy_ff        <= '0;
         sz_ff        <= '0;
         tol_ff       <= TOL_W'(6554);
         align_ok_ff  <= 1'b0;
         fail_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            cx_ff[k] <= '0;
            cy_ff[k] <= '0;
            cz_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_GRID_POWER: power_ff <= csr_wdata[PW-1:0];
               CSR_START_X:    sx_ff    <= csr_wdata;
               CSR_START_Y:    sy_ff    <= csr_wdata;
               CSR_START_Z:    sz_ff    <= csr_wdata;
               CSR_TOLERANCE:  tol_ff   <= csr_wdata[TOL_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load_corner) begin
            cx_ff[corner] <= ax;
            cy_ff[corner] <= ay;
            cz_ff[corner] <= az;
         end
         if (cmd.rotate) begin
            for (int k = 0; k < 4; k++) begin
               cx_ff[k] <= cx_ff[(k + 1) % 4];
               cy_ff[k] <= cy_ff[(k + 1) % 4];
               cz_ff[k] <= cz_ff[(k + 1) % 4];
            end
         end
         if (cmd.align_done) begin
            align_ok_ff <= cmd.align_ok;
            fail_ff     <= !cmd.align_ok;
            row_ff      <= '0;
            col_ff      <= '0;
         end
         // advance to the next grid point; the latched copies feed the math
         if (cmd.latch) begin
            if (col_ff + CNT_W'(1) > n) begin
               col_ff <= '0;
               row_ff <= row_ff + CNT_W'(1);
            end else begin
               col_ff <= col_ff + CNT_W'(1);
            end
         end
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         r_ff    <= row_ff;
         c_ff    <= col_ff;
         dx_ff   <= ax;
         dy_ff   <= ay;
         dz_ff   <= az;
         dist_ff <= dist_req;
      end
      l_ff    <= l_in;
      rr_ff   <= rr_in;
      prod_ff <= prod_in;
      axa_ff  <= cmd.step[1:0];
      axb_ff  <= axa_ff;
      num_ff  <= num_in;
      d_ff    <= prod_r[DW-1:0];
      if (cmd.calc && cmd.step >= CALC_WR_STEP) begin
         unique case (axb_ff)
            2'd0:    vx_ff[0] <= sat;
            2'd1:    vx_ff[1] <= sat;
            default: vx_ff[2] <= sat;
         endcase
      end
      if (cmd.out_load) begin
         last_ff   <= cmd.out_last;
         status_ff <= 1'b0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         oz_ff     <= '0;
         ta_ff     <= '0;
         tb_ff     <= '0;
         tc_ff     <= '0;
         unique case (cmd.out_sel)
            RES_STATUS: begin
               kind_ff   <= KIND_STATUS;
               status_ff <= fail_ff;
            end
            RES_VERTEX: begin
               kind_ff <= KIND_VERTEX;
               ox_ff   <= vx_ff[0];
               oy_ff   <= vx_ff[1];
               oz_ff   <= vx_ff[2];
            end
            RES_TRI0: begin
               kind_ff <= KIND_TRI;
               if (idx[0]) begin
                  ta_ff <= idx; tb_ff <= i1;  tc_ff <= iw;
               end else begin
                  ta_ff <= idx; tb_ff <= iw1; tc_ff <= iw;
               end
            end
            default: begin
               kind_ff <= KIND_TRI;
               if (idx[0]) begin
                  ta_ff <= i1;  tb_ff <= iw1; tc_ff <= iw;
               end else begin
                  ta_ff <= idx; tb_ff <= i1;  tc_ff <= iw1;
               end
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign kind       = kind_ff;
   assign status     = status_ff;
   assign ox         = ox_ff;
   assign oy         = oy_ff;
   assign oz         = oz_ff;
   assign tri_a      = ta_ff;
   assign tri_b      = tb_ff;
   assign tri_c      = tc_ff;
   assign last       = last_ff;

endmodule

/* rtl/core/displacement_grid_tessellator.sv */
// channel | dir | beat contents
// req     | in  | tuser: func; tdata: corner, ax, ay, az, dist_req
// rsp     | out | tuser: kind; tlast: last; tdata: status, ox, oy, oz, tri_a/b/c
// csr     | in  | write enable, register index, write data
//
// One item at a time. Load writes its corner on accept. Begin: accept, then a match check
// per corner order until one matches or all orders fail, then the status beat. Vertex: accept,
// then the three-stage axis pipeline (one axis enters per cycle), then 1 or 3 beats,
// each held until rsp_tready takes it.
// The result register frees the input while the final beat waits on rsp_tready.
// Reset is synchronous; it clears corners and counters and restores config defaults.
module displacement_grid_tessellator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dgt_pkg::REQ_DW-1:0]    req_tdata,  // corner, ax, ay, az, dist_req, pad
   input  logic [1:0]                    req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dgt_pkg::RSP_DW-1:0]    rsp_tdata,  // status, ox, oy, oz, tri_a, tri_b, tri_c, pad
   output logic [1:0]                    rsp_tuser,  // kind
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [dgt_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [dgt_pkg::CW-1:0]        csr_wdata
);
   import dgt_pkg::*;

   cmd_type              cmd;
   stat_type             stat;
   logic [1:0]           kind;
   logic                 status, last;
   logic signed [CW-1:0] ox, oy, oz;
   logic [IDX_W-1:0]     tri_a, tri_b, tri_c;

   dgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .func       (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   dgt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .corner     (req_tdata[1:0]),
      .ax         (req_tdata[33:2]),
      .ay         (req_tdata[65:34]),
      .az         (req_tdata[97:66]),
      .dist_req   (req_tdata[129:98]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .kind       (kind),
      .status     (status),
      .ox         (ox),
      .oy         (oy),
      .oz         (oz),
      .tri_a      (tri_a),
      .tri_b      (tri_b),
      .tri_c      (tri_c),
      .last       (last)
   );

   assign rsp_tdata = {4'b0, tri_c, tri_b, tri_a, oz, oy, ox, status};
   assign rsp_tuser = kind;
   assign rsp_tlast = last;

endmodule

/* verif/tess_checker.sv */
module tess_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [dgt_pkg::REQ_DW-1:0] req_tdata,  // corner, ax, ay, az, dist_req, pad
   input  logic [1:0]                 req_tuser,  // func
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [dgt_pkg::RSP_DW-1:0] rsp_tdata,  // status, ox, oy, oz, tri_a, tri_b, tri_c, pad
   input  logic [1:0]                 rsp_tuser,  // kind
   input  logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [dgt_pkg::CSR_AW-1:0] csr_addr,
   input  logic [dgt_pkg::CW-1:0]     csr_wdata,
   output int                         errors,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dgt_pkg::*;

   typedef struct {
      logic [1:0]        kind;
      logic              status;
      logic signed [31:0] ox, oy, oz;
      logic [8:0]        ta, tb, tc;
      logic              last;
   } tess_beat_type;

   tess_beat_type expected_beats[$];

   logic [2:0]         power_reg;
   logic signed [31:0] start_pos[3];
   logic [19:0]        tolerance;
   logic signed [31:0] quad[3][4];
   logic               aligned;
   int                 row, col;

   function automatic longint grid_point(input longint c0, c1, c2, c3, input int p,
                                         input longint r, cc,
                                         input logic signed [31:0] dir, dist_val);
      longint n, l, rr, b, d, s;
      n  = longint'(1) << p;
      l  = c0 * n + (c1 - c0) * r;
      rr = c3 * n + (c2 - c3) * r;
      b  = (l * n + (rr - l) * cc + (longint'(1) << (2 * p - 1))) >>> (2 * p);
      d  = (longint'(dir) * longint'(dist_val) + 32768) >>> 16;
      s  = b + d;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   function automatic bit corner0_near();
      longint dlt;
      for (int a = 0; a < 3; a++) begin
         dlt = longint'(quad[a][0]) - longint'(start_pos[a]);
         if (dlt < 0) dlt = -dlt;
         if (dlt > longint'(tolerance)) return 0;
      end
      return 1;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic queue_beat(input tess_beat_type bt);
      expected_beats.insert(expected_beats.size(), bt);
   endtask

   task automatic predict();
      tess_beat_type bt;
      int p, n, idx, w;
      logic signed [31:0] t, dirv[3], dist_val;
      logic ok;
      p = (power_reg < 1) ? 1 : (power_reg > MAX_POWER) ? MAX_POWER : power_reg;
      n = 1 << p;
      bt = '{default: 0};
      dirv[0]  = req_tdata[33:2];
      dirv[1]  = req_tdata[65:34];
      dirv[2]  = req_tdata[97:66];
      dist_val = req_tdata[129:98];
      case (req_tuser)
         FUNC_LOAD: begin
            for (int a = 0; a < 3; a++) quad[a][req_tdata[1:0]] = dirv[a];
         end
         FUNC_BEGIN: begin
            ok = 0;
            for (int k = 0; k < 4 && !ok; k++) begin
               if (corner0_near()) ok = 1;
               else begin
                  for (int a = 0; a < 3; a++) begin
                     t = quad[a][0];
                     quad[a][0] = quad[a][1];
                     quad[a][1] = quad[a][2];
                     quad[a][2] = quad[a][3];
                     quad[a][3] = t;
                  end
               end
            end
            aligned = ok;
            row = 0;
            col = 0;
            bt.kind = KIND_STATUS;
            bt.status = !ok;
            bt.last = 1;
            queue_beat(bt);
         end
         FUNC_VERTEX: begin
            if (aligned && row <= n && col <= n) begin
               bt.kind = KIND_VERTEX;
               bt.ox = grid_point(quad[0][0], quad[0][1], quad[0][2], quad[0][3], p, row, col,
                                  dirv[0], dist_val);
               bt.oy = grid_point(quad[1][0], quad[1][1], quad[1][2], quad[1][3], p, row, col,
                                  dirv[1], dist_val);
               bt.oz = grid_point(quad[2][0], quad[2][1], quad[2][2], quad[2][3], p, row, col,
                                  dirv[2], dist_val);
               bt.last = !(row >= 1 && col >= 1);
               queue_beat(bt);
               if (row >= 1 && col >= 1) begin
                  w = n + 1;
                  idx = (row - 1) * w + (col - 1);
                  bt = '{default: 0};
                  bt.kind = KIND_TRI;
                  // odd cells split along the other diagonal
                  if (idx % 2) begin
                     bt.ta = idx; bt.tb = idx + 1; bt.tc = idx + w;
                     queue_beat(bt);
                     bt.ta = idx + 1; bt.tb = idx + w + 1; bt.tc = idx + w; bt.last = 1;
                  end else begin
                     bt.ta = idx; bt.tb = idx + w + 1; bt.tc = idx + w;
                     queue_beat(bt);
                     bt.ta = idx; bt.tb = idx + 1; bt.tc = idx + w + 1; bt.last = 1;
                  end
                  queue_beat(bt);
               end
               col++;
               if (col > n) begin
                  col = 0;
                  row++;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare();
      tess_beat_type e;
      if (expected_beats.size() == 0) begin
         report("beat with none expected, kind", rsp_tuser, -1);
         return;
      end
      e = expected_beats.pop_front();
      if (rsp_tuser != e.kind) report("kind", rsp_tuser, e.kind);
      if (rsp_tlast != e.last) report("last", rsp_tlast, e.last);
      if (rsp_tdata[0] != e.status) report("status", rsp_tdata[0], e.status);
      if ($signed(rsp_tdata[32:1]) != e.ox) report("ox", $signed(rsp_tdata[32:1]), e.ox);
      if ($signed(rsp_tdata[64:33]) != e.oy) report("oy", $signed(rsp_tdata[64:33]), e.oy);
      if ($signed(rsp_tdata[96:65]) != e.oz) report("oz", $signed(rsp_tdata[96:65]), e.oz);
      if (rsp_tdata[105:97] != e.ta) report("tri_a", rsp_tdata[105:97], e.ta);
      if (rsp_tdata[114:106] != e.tb) report("tri_b", rsp_tdata[114:106], e.tb);
      if (rsp_tdata[123:115] != e.tc) report("tri_c", rsp_tdata[123:115], e.tc);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         power_reg = 2;
         start_pos = '{0, 0, 0};
         tolerance = 6554;
         quad = '{default: '{default: 0}};
         aligned = 0;
         row = 0;
         col = 0;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_GRID_POWER: power_reg = csr_wdata[2:0];
               CSR_START_X:    start_pos[0] = csr_wdata;
               CSR_START_Y:    start_pos[1] = csr_wdata;
               CSR_START_Z:    start_pos[2] = csr_wdata;
               CSR_TOLERANCE:  tolerance = csr_wdata[19:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict();
         if (rsp_tvalid && rsp_tready) compare();
      end
      pending = expected_beats.size();
   end
endmodule

/* verif/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dgt_pkg::*;

   localparam logic [1:0] FUNC_RSVD = 2'd3;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;  // corner, ax, ay, az, dist_req, pad
   logic [1:0]        req_tuser = '0;  // func
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [RSP_DW-1:0] rsp_tdata;       // status, ox, oy, oz, tri_a, tri_b, tri_c, pad
   logic [1:0]        rsp_tuser;       // kind
   logic              rsp_tlast;
   logic              csr_we = 0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CW-1:0]     csr_wdata = '0;
   int                errors, pending;

   int  send_idle = 36, recv_idle = 62;
   int  items_sent = 0;
   int  stall_left = 0;
   bit  stall_req = 0;
   bit  valid_dropped = 0;
   int  cycles = 0;
   logic signed [31:0] start_pos[3];

   always #5 clock = ~clock;

   displacement_grid_tessellator dut (.*);

   tess_checker chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("timeout");
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: long hold-off on request, random backpressure otherwise
   always @(posedge clock) begin
      if (stall_req) begin
         stall_req = 0;
         stall_left = 400;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [31:0] rnd32();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(262143) - 131072;
         2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(2000000) - 1000000;
      endcase
   endfunction

   task automatic send(input logic [1:0] func, input logic [1:0] corner,
                       input logic [31:0] ax, ay, az, dist_val);
      req_tuser  <= func;
      req_tdata  <= {6'd0, dist_val, az, ay, ax, corner};
      req_tvalid <= 1;
      valid_dropped = 0;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (items_sent > 50) begin
         send_idle = 62; recv_idle = 36;
      end
      if (items_sent > 100) begin
         send_idle = 0; recv_idle = 0;
      end
      // hold the receiver off while items keep coming
      if (items_sent == 100) stall_req = 1;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         valid_dropped = 1;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic settle();
      if (!valid_dropped) req_tvalid <= 0;
      valid_dropped = 1;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] idx, input logic [CW-1:0] val);
      @(posedge clock);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
      if (idx >= CSR_START_X && idx <= CSR_START_Z) start_pos[idx - CSR_START_X] = val;
   endtask

   // load four corners with a start match at slot hit (none when hit > 3), then begin
   task automatic load_quad(input int hit, input int tol);
      logic [31:0] v[3];
      for (int k = 0; k < 4; k++) begin
         for (int a = 0; a < 3; a++)
            v[a] = (k == hit) ? start_pos[a] + $urandom_range(2 * tol) - tol : rnd32();
         send(FUNC_LOAD, 2'(k), v[0], v[1], v[2], $urandom);
      end
      send(FUNC_BEGIN, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int p, tol, npts;
      start_pos = '{0, 0, 0};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset config, corner at slot 2, saturating vertices
      load_quad(2, 6000);
      send(FUNC_VERTEX, 0, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
      send(FUNC_VERTEX, 3, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send(FUNC_RSVD, 1, $urandom, $urandom, $urandom, $urandom);
      for (int k = 0; k < 4; k++) send(FUNC_VERTEX, 0, rnd32(), rnd32(), rnd32(), rnd32());
      send(FUNC_LOAD, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
      send(FUNC_VERTEX, 0, 0, 0, 0, 0);
      // alignment failure, then an ignored vertex
      load_quad(5, 0);
      send(FUNC_VERTEX, 0, rnd32(), rnd32(), rnd32(), rnd32());
      settle();
      // power out of range low, tolerance zero
      csr_write(CSR_GRID_POWER, 0);
      csr_write(CSR_TOLERANCE, 0);
      csr_write(CSR_START_X, 32'h80000000);
      csr_write(CSR_START_Y, 32'h7fffffff);
      csr_write(CSR_START_Z, 0);
      load_quad(0, 0);
      for (int k = 0; k < 11; k++) send(FUNC_VERTEX, 2'(k), rnd32(), rnd32(), rnd32(), rnd32());
      settle();
      // largest power, then shrink mid-surface so the grid reads complete
      csr_write(CSR_GRID_POWER, 7);
      csr_write(CSR_TOLERANCE, 20'hfffff);
      load_quad(3, 20'hfffff);
      for (int k = 0; k < 20; k++) send(FUNC_VERTEX, 2'(k), rnd32(), rnd32(), rnd32(), rnd32());
      settle();
      csr_write(CSR_GRID_POWER, 1);
      send(FUNC_VERTEX, 0, rnd32(), rnd32(), rnd32(), rnd32());
      settle();

      while (items_sent < 150) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: p = 1;
            5, 6, 7: p = 2;
            8: p = 3;
            default: p = $urandom_range(1) ? 0 : 7;
         endcase
         tol = $urandom_range(3) == 0 ? ($urandom_range(1) ? 0 : 20'hfffff)
                                      : $urandom_range(20'hfffff);
         csr_write(CSR_GRID_POWER, p);
         csr_write(CSR_TOLERANCE, tol);
         csr_write(CSR_START_X, rnd32());
         csr_write(CSR_START_Y, rnd32());
         csr_write(CSR_START_Z, rnd32());
         if (p < 1) p = 1;
         if (p > MAX_POWER) p = MAX_POWER;
         if (p == MAX_POWER) p = 1;  // keep the grid short after the power check
         load_quad($urandom_range(9) == 0 ? 5 : $urandom_range(3), tol);
         npts = ((1 << p) + 1) * ((1 << p) + 1) + $urandom_range(2);
         for (int k = 0; k < npts && items_sent < 150; k++) begin
            case ($urandom_range(19))
               0: send(FUNC_RSVD, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
               1: send(FUNC_LOAD, 2'($urandom), rnd32(), rnd32(), rnd32(), $urandom);
               default: send(FUNC_VERTEX, 2'($urandom), rnd32(), rnd32(), rnd32(), rnd32());
            endcase
         end
         settle();
      end

      settle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
